### hdl/assert_macros.svh
// Assertion macros for the flood block's RTL; only pft_back includes them.
// No dependencies; each macro compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PFT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PFT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFT_ASSERT(lbl, clk, rst, prop, msg)
`define PFT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### hdl/pft_pkg.sv
// Package for the trapped-water flood block: word types, register codes,
// state encoding and the neighbor step tables. No dependencies.
package pft_pkg;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLS_DEF    = 64;
  localparam int HEIGHT_BITS_DEF = 16;

  localparam int CFG_W    = 7;
  localparam int HEIGHT_W = 16;
  localparam int WATER_W  = 28;
  localparam int DIM_W    = 11;
  localparam int IDX_W    = 2;

  localparam logic [WATER_W-1:0] WATER_MAX = {WATER_W{1'b1}};
  localparam logic [CFG_W-1:0]   DIM_RESET = 7'd64;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_COLS = 2'd1;

  // Neighbor steps: down, right, up, left.
  localparam logic signed [1:0] ROW_STEP [4] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0};
  localparam logic signed [1:0] COL_STEP [4] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};

  typedef struct packed {
    logic [HEIGHT_W-1:0] cell_height;
    logic                last_cell;
  } cell_in_t;

  typedef struct packed {
    logic [WATER_W-1:0] water_total;
    logic               status;
  } result_t;

  // One finished grid handed from the loader to the flood engine.
  typedef struct packed {
    logic             ok;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
  } job_t;

  typedef enum logic [4:0] {
    B_IDLE, B_CLEAR, B_SEED_RD, B_SEED_CHK, B_SEED_NEXT,
    B_PUSH, B_PUSH_CMP, B_LOOP, B_POP_TOP, B_POP_LAST,
    B_SIFT, B_SIFT_L, B_SIFT_R, B_SIFT_MOVE,
    B_NB, B_NB_RD, B_NB_CHK, B_NB_NEXT, B_RESULT
  } back_state_e;

endpackage

### hdl/pft_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module pft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/pft_front.sv
// Loader: holds the grid size registers, stores incoming heights and
// checks the cell count. Depends on pft_pkg.
module pft_front #(
  parameter int MAX_ROWS    = pft_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = pft_pkg::MAX_COLS_DEF,
  parameter int HEIGHT_BITS = pft_pkg::HEIGHT_BITS_DEF,
  parameter int CAP         = MAX_ROWS * MAX_COLS,
  parameter int AW          = (CAP > 1) ? $clog2(CAP) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pft_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pft_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       push,
  input  pft_pkg::cell_in_t          item,
  output logic                       full,
  input  logic                       hold,
  output logic                       hs_we,
  output logic [AW-1:0]              hs_waddr,
  output logic [HEIGHT_BITS-1:0]     hs_wdata,
  output logic                       job_push,
  output pft_pkg::job_t              job
);
  import pft_pkg::*;

  localparam int CNT_W = $clog2(CAP + 2);

  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;
  logic [CNT_W-1:0] cells_loaded;
  logic [CNT_W-1:0] cnt_inc;
  logic             accept;
  logic [13:0]      area;
  logic             dims_ok;

  assign cfg_ready = 1'b1;
  assign full      = hold;
  assign accept    = push && !full;

  // Count saturates one past capacity so an oversize grid reports an error.
  assign cnt_inc = (cells_loaded <= CNT_W'(CAP)) ? cells_loaded + CNT_W'(1) : cells_loaded;
  assign area    = 14'(grid_rows) * 14'(grid_cols);
  assign dims_ok = (grid_rows != '0) && (32'(grid_rows) <= 32'(MAX_ROWS)) &&
                   (grid_cols != '0) && (32'(grid_cols) <= 32'(MAX_COLS));

  // Height store write.
  assign hs_we    = accept && (cells_loaded < CNT_W'(CAP));
  assign hs_waddr = AW'(cells_loaded);
  assign hs_wdata = HEIGHT_BITS'(item.cell_height);

  // Grid descriptor on the marked cell.
  assign job_push = accept && item.last_cell;
  assign job.ok   = dims_ok && (32'(cnt_inc) == 32'(area));
  assign job.rows = grid_rows;
  assign job.cols = grid_cols;

  // Configuration registers and cell counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= DIM_RESET;
      grid_cols    <= DIM_RESET;
      cells_loaded <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_ROWS: grid_rows <= cfg_data;
          REG_GRID_COLS: grid_cols <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        cells_loaded <= item.last_cell ? '0 : cnt_inc;
      end
    end
  end

endmodule

### hdl/pft_jobq.sv
// Two-entry queue of grid descriptors between loader and flood engine.
// Depends on pft_pkg.
module pft_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pft_pkg::job_t din,
  input  logic          pop,
  output pft_pkg::job_t dout,
  output logic          empty
);
  import pft_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign empty   = (count == 2'd0);
  assign dout    = slots[rd_ptr];
  assign do_push = push && (count != 2'd2);
  assign do_pop  = pop && !empty;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

### hdl/pft_back.sv
// Flood engine: clears the visited map, seeds the border into a binary
// min-heap in RAM and runs the priority flood. Depends on pft_pkg, pft_ram.
`include "assert_macros.svh"
module pft_back #(
  parameter int MAX_ROWS    = pft_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = pft_pkg::MAX_COLS_DEF,
  parameter int HEIGHT_BITS = pft_pkg::HEIGHT_BITS_DEF,
  parameter int CAP         = MAX_ROWS * MAX_COLS,
  parameter int AW          = (CAP > 1) ? $clog2(CAP) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pft_pkg::job_t          job,
  input  logic                   job_empty,
  output logic                   job_pop,
  output logic                   busy,
  output logic [AW-1:0]          hs_raddr,
  input  logic [HEIGHT_BITS-1:0] hs_rdata,
  output pft_pkg::result_t       result,
  output logic                   empty,
  input  logic                   pop
);
  import pft_pkg::*;

  localparam int HCW = $clog2(CAP + 1);
  localparam int RB  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int HB  = HEIGHT_BITS;
  localparam int EW  = HB + RB + CB;
  localparam int SW  = ((HB > WATER_W) ? HB : WATER_W) + 1;

  back_state_e state, state_next;

  logic [CFG_W-1:0]   rows, cols;
  logic [HCW-1:0]     total, k, heap_cnt, hi, best_idx;
  logic [RB-1:0]      r, nb_r;
  logic [CB-1:0]      c, nb_c;
  logic [EW-1:0]      ent, best, cur;
  logic               bsel, ret_seed, err, res_valid;
  logic [1:0]         dir;
  logic [AW-1:0]      nb_addr;
  logic [WATER_W-1:0] water;

  // RAM ports.
  logic          vis_we, vis_wdata, vis_rd;
  logic [AW-1:0] vis_waddr, vis_raddr;
  logic          heap_we;
  logic [AW-1:0] heap_waddr, heap_raddr;
  logic [EW-1:0] heap_wdata, heap_rd;

  // Derived values.
  logic [HB-1:0]        ent_lvl, rd_lvl, best_lvl, cur_lvl, nb_lvl, diff;
  logic [HCW-1:0]       parent;
  logic [HCW:0]         lidx, ridx;
  logic                 l_in, r_in, border, last_k, up_ok, res_free, nb_ok;
  logic signed [DIM_W:0] r1, c1;
  logic [2*DIM_W-1:0]   n_full;
  logic [SW-1:0]        sum;

  pft_ram #(.WIDTH(1), .DEPTH(CAP)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rd)
  );

  pft_ram #(.WIDTH(EW), .DEPTH(CAP)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rd)
  );

  assign ent_lvl  = ent[EW-1 -: HB];
  assign rd_lvl   = heap_rd[EW-1 -: HB];
  assign best_lvl = best[EW-1 -: HB];
  assign cur_lvl  = cur[EW-1 -: HB];
  assign up_ok    = rd_lvl <= ent_lvl;
  assign parent   = (hi - HCW'(1)) >> 1;
  assign lidx     = {hi, 1'b1};
  assign ridx     = {hi, 1'b0} + (HCW + 1)'(2);
  assign l_in     = lidx < {1'b0, heap_cnt};
  assign r_in     = ridx < {1'b0, heap_cnt};
  assign last_k   = (k == total - HCW'(1));
  assign res_free = !res_valid || pop;
  assign busy     = (state != B_IDLE) && (state != B_RESULT);
  assign empty    = !res_valid;

  assign border = (r == '0) || (c == '0) ||
                  (DIM_W'(r) == DIM_W'(rows) - DIM_W'(1)) ||
                  (DIM_W'(c) == DIM_W'(cols) - DIM_W'(1));

  // Neighbor position and range check.
  assign r1 = signed'((DIM_W + 1)'(cur[CB +: RB])) + (DIM_W + 1)'(ROW_STEP[dir]);
  assign c1 = signed'((DIM_W + 1)'(cur[0 +: CB])) + (DIM_W + 1)'(COL_STEP[dir]);
  assign nb_ok = (r1 >= 0) && (r1 < signed'((DIM_W + 1)'(rows))) &&
                 (c1 >= 0) && (c1 < signed'((DIM_W + 1)'(cols)));
  assign n_full = (2 * DIM_W)'(DIM_W'(r1)) * (2 * DIM_W)'(cols) + (2 * DIM_W)'(DIM_W'(c1));

  // Water for a neighbor below the current level, saturating.
  assign nb_lvl = (cur_lvl > hs_rdata) ? cur_lvl : hs_rdata;
  assign diff   = (cur_lvl > hs_rdata) ? cur_lvl - hs_rdata : '0;
  assign sum    = SW'(water) + SW'(diff);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:      if (!job_empty) state_next = job.ok ? B_CLEAR : B_RESULT;
      B_CLEAR:     if (last_k) state_next = B_SEED_RD;
      B_SEED_RD:   state_next = B_SEED_CHK;
      B_SEED_CHK:  state_next = border ? B_PUSH : B_SEED_NEXT;
      B_SEED_NEXT: state_next = last_k ? B_LOOP : B_SEED_RD;
      B_PUSH: begin
        if (hi == '0) state_next = ret_seed ? B_SEED_NEXT : B_NB_NEXT;
        else          state_next = B_PUSH_CMP;
      end
      B_PUSH_CMP: begin
        if (up_ok) state_next = ret_seed ? B_SEED_NEXT : B_NB_NEXT;
        else       state_next = B_PUSH;
      end
      B_LOOP:      state_next = (heap_cnt == '0) ? B_RESULT : B_POP_TOP;
      B_POP_TOP:   state_next = B_POP_LAST;
      B_POP_LAST:  state_next = B_SIFT;
      B_SIFT:      state_next = l_in ? B_SIFT_L : B_NB;
      B_SIFT_L:    state_next = r_in ? B_SIFT_R : B_SIFT_MOVE;
      B_SIFT_R:    state_next = B_SIFT_MOVE;
      B_SIFT_MOVE: state_next = bsel ? B_SIFT : B_NB;
      B_NB:        state_next = nb_ok ? B_NB_RD : B_NB_NEXT;
      B_NB_RD:     state_next = B_NB_CHK;
      B_NB_CHK:    state_next = !vis_rd ? B_PUSH : B_NB_NEXT;
      B_NB_NEXT:   state_next = (dir == 2'd3) ? B_LOOP : B_NB;
      B_RESULT:    if (res_free) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    job_pop    = 1'b0;
    hs_raddr   = '0;
    vis_we     = 1'b0;
    vis_waddr  = '0;
    vis_wdata  = 1'b0;
    vis_raddr  = '0;
    heap_we    = 1'b0;
    heap_waddr = '0;
    heap_wdata = ent;
    heap_raddr = '0;
    unique case (state)
      B_IDLE:  job_pop = !job_empty;
      B_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = AW'(k);
      end
      B_SEED_RD: hs_raddr = AW'(k);
      B_SEED_CHK: begin
        vis_we    = border;
        vis_waddr = AW'(k);
        vis_wdata = 1'b1;
      end
      B_PUSH: begin
        if (hi == '0) heap_we = 1'b1;
        else          heap_raddr = AW'(parent);
      end
      B_PUSH_CMP: begin
        heap_we    = 1'b1;
        heap_waddr = AW'(hi);
        heap_wdata = up_ok ? ent : heap_rd;
      end
      B_POP_TOP: heap_raddr = AW'(heap_cnt - HCW'(1));
      B_SIFT: begin
        if (l_in) begin
          heap_raddr = AW'(lidx);
        end else begin
          heap_we    = 1'b1;
          heap_waddr = AW'(hi);
        end
      end
      B_SIFT_L: heap_raddr = AW'(ridx);
      B_SIFT_MOVE: begin
        heap_we    = 1'b1;
        heap_waddr = AW'(hi);
        heap_wdata = bsel ? best : ent;
      end
      B_NB_RD: begin
        vis_raddr = nb_addr;
        hs_raddr  = nb_addr;
      end
      B_NB_CHK: begin
        vis_we    = !vis_rd;
        vis_waddr = nb_addr;
        vis_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      heap_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // A new result may replace the one popped in the same cycle.
      if ((state == B_RESULT) && res_free) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_SEED_CHK: if (border) heap_cnt <= heap_cnt + HCW'(1);
        B_POP_TOP:  heap_cnt <= heap_cnt - HCW'(1);
        B_NB_CHK:   if (!vis_rd) heap_cnt <= heap_cnt + HCW'(1);
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        rows  <= job.rows;
        cols  <= job.cols;
        total <= HCW'(job.rows) * HCW'(job.cols);
        err   <= !job.ok;
        k     <= '0;
        r     <= '0;
        c     <= '0;
        water <= '0;
      end
      B_CLEAR: k <= last_k ? '0 : k + HCW'(1);
      B_SEED_CHK: begin
        ent      <= {hs_rdata, r, c};
        hi       <= heap_cnt;
        ret_seed <= 1'b1;
      end
      B_SEED_NEXT: begin
        k <= k + HCW'(1);
        if (DIM_W'(c) == DIM_W'(cols) - DIM_W'(1)) begin
          c <= '0;
          r <= r + RB'(1);
        end else begin
          c <= c + CB'(1);
        end
      end
      B_PUSH_CMP: if (!up_ok) hi <= parent;
      B_POP_TOP: begin
        cur <= heap_rd;
        dir <= 2'd0;
      end
      B_POP_LAST: begin
        ent <= heap_rd;
        hi  <= '0;
      end
      B_SIFT_L: begin
        best     <= heap_rd;
        best_idx <= HCW'(lidx);
        bsel     <= rd_lvl < ent_lvl;
      end
      B_SIFT_R: begin
        if (bsel ? (rd_lvl < best_lvl) : (rd_lvl < ent_lvl)) begin
          best     <= heap_rd;
          best_idx <= HCW'(ridx);
          bsel     <= 1'b1;
        end
      end
      B_SIFT_MOVE: if (bsel) hi <= best_idx;
      B_NB: begin
        nb_addr <= AW'(n_full);
        nb_r    <= RB'(r1);
        nb_c    <= CB'(c1);
      end
      B_NB_CHK: begin
        if (!vis_rd) begin
          water    <= (sum > SW'(WATER_MAX)) ? WATER_MAX : WATER_W'(sum);
          ent      <= {nb_lvl, nb_r, nb_c};
          hi       <= heap_cnt;
          ret_seed <= 1'b0;
        end
      end
      B_NB_NEXT: dir <= dir + 2'd1;
      B_RESULT: begin
        if (res_free) begin
          result.water_total <= err ? '0 : water;
          result.status      <= err;
        end
      end
      default: ;
    endcase
  end

  `PFT_ASSERT(a_heap_bound, clk, rst, 32'(heap_cnt) <= 32'(CAP), "heap count above capacity")
  `PFT_ASSERT(a_heap_drained, clk, rst, (state == B_RESULT) |-> (heap_cnt == '0), "heap not empty at result")
  `PFT_ASSERT(a_sift_index, clk, rst, (state == B_SIFT) |-> (hi <= heap_cnt), "sift index past heap end")
  `PFT_ASSERT_NR(a_reset_idle, clk, $past(rst) |-> ((state == B_IDLE) && !res_valid), "not idle after reset")

endmodule

### hdl/priority_flood_trapped_water.sv
// Trapped-water volume over a 2D height grid by priority flood. Heights
// arrive one word per cycle in row-major order while full is low; the word
// marked last_cell closes the grid and yields one result word. Loading runs
// at one cell per cycle while not held off. The flood first clears the
// visited map, then scans every cell for the border and pushes each border
// cell onto the heap with a sift-up; for each popped cell it sifts the heap
// down in the heap RAM and runs up to 4 neighbor checks, pushing each
// unvisited one with a sift-up. Input is held off while a flood runs or a
// grid waits to be flooded; a finished result sits in an output register,
// so the next grid can load while it waits.
// Depends on pft_pkg, pft_ram, pft_front, pft_jobq, pft_back.
module priority_flood_trapped_water #(
  parameter int MAX_ROWS    = pft_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = pft_pkg::MAX_COLS_DEF,
  parameter int HEIGHT_BITS = pft_pkg::HEIGHT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pft_pkg::IDX_W-1:0] cfg_index,
  input  logic [pft_pkg::CFG_W-1:0] cfg_data,
  input  logic                      push,
  input  pft_pkg::cell_in_t         item,
  output logic                      full,
  output pft_pkg::result_t          result,
  output logic                      empty,
  input  logic                      pop
);
  import pft_pkg::*;

  localparam int CAP = MAX_ROWS * MAX_COLS;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;

  logic                   hs_we;
  logic [AW-1:0]          hs_waddr, hs_raddr;
  logic [HEIGHT_BITS-1:0] hs_wdata, hs_rdata;
  logic                   job_push, job_pop, job_empty, back_busy, hold;
  job_t                   job_in, job_out;

  // Heights stay fixed while a grid is queued or being flooded.
  assign hold = back_busy || !job_empty;

  pft_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .HEIGHT_BITS(HEIGHT_BITS)) u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .item(item), .full(full), .hold(hold),
    .hs_we(hs_we), .hs_waddr(hs_waddr), .hs_wdata(hs_wdata),
    .job_push(job_push), .job(job_in)
  );

  pft_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(CAP)) u_heights (
    .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
    .raddr(hs_raddr), .rdata(hs_rdata)
  );

  pft_jobq u_jobq (
    .clk(clk), .rst(rst), .push(job_push), .din(job_in),
    .pop(job_pop), .dout(job_out), .empty(job_empty)
  );

  pft_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .HEIGHT_BITS(HEIGHT_BITS)) u_back (
    .clk(clk), .rst(rst),
    .job(job_out), .job_empty(job_empty), .job_pop(job_pop), .busy(back_busy),
    .hs_raddr(hs_raddr), .hs_rdata(hs_rdata),
    .result(result), .empty(empty), .pop(pop)
  );

endmodule

### sim/tb_top.sv
// Self-checking testbench for the trapped-water priority flood block.
// Depends on pft_pkg and priority_flood_trapped_water; holds its own flood predictor.
`timescale 1ns / 1ps

module tb_top;
  import pft_pkg::*;

  localparam int CELL_CAP   = 4096;
  localparam int WATCH_MAX  = 1000000;
  localparam int SETTLE     = 60;
  localparam int HOLD_LEN   = 3000;

  typedef enum int {FILL_ZERO, FILL_MAX, FILL_BOWL} fill_e;

  typedef struct {
    int      rows;
    int      cols;
    bit      junk_write;
    int      count;
    fill_e   fill;
    result_t want;
  } grid_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             push = 1'b0;
  cell_in_t         item = '0;
  logic             full;
  result_t          result;
  logic             empty;
  logic             pop = 1'b0;

  priority_flood_trapped_water i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push), .item(item), .full(full),
    .result(result), .empty(empty), .pop(pop)
  );

  always #5 clk = ~clk;

  // Predictor state: registers, stored heights, flood heap and visited map.
  logic [CFG_W-1:0]   grid_rows_q = DIM_RESET;
  logic [CFG_W-1:0]   grid_cols_q = DIM_RESET;
  logic [HEIGHT_W-1:0] heights [CELL_CAP];
  bit                 seen [CELL_CAP];
  int unsigned        heap_lvl [CELL_CAP];
  int                 heap_pos [CELL_CAP];
  int                 heap_n;
  int                 cells_in;

  result_t            pending_totals [$];
  int                 send_idle_pct = 28;
  int                 recv_idle_pct = 50;
  bit                 hold_req = 0;
  int                 mismatches = 0;
  int                 grids_done = 0;
  int                 words_sent = 0;
  int                 results_seen = 0;
  int                 idle_cycles = 0;

  function automatic void heap_insert(int unsigned lvl, int pos);
    int i, p;
    int unsigned tl;
    int tp;
    i = heap_n++;
    heap_lvl[i] = lvl;
    heap_pos[i] = pos;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_lvl[p] <= heap_lvl[i]) break;
      tl = heap_lvl[p]; heap_lvl[p] = heap_lvl[i]; heap_lvl[i] = tl;
      tp = heap_pos[p]; heap_pos[p] = heap_pos[i]; heap_pos[i] = tp;
      i = p;
    end
  endfunction

  function automatic void heap_take(output int unsigned lvl, output int pos);
    int i, l, r, m;
    int unsigned tl;
    int tp;
    lvl = heap_lvl[0];
    pos = heap_pos[0];
    heap_n--;
    heap_lvl[0] = heap_lvl[heap_n];
    heap_pos[0] = heap_pos[heap_n];
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < heap_n && heap_lvl[l] < heap_lvl[m]) m = l;
      if (r < heap_n && heap_lvl[r] < heap_lvl[m]) m = r;
      if (m == i) break;
      tl = heap_lvl[m]; heap_lvl[m] = heap_lvl[i]; heap_lvl[i] = tl;
      tp = heap_pos[m]; heap_pos[m] = heap_pos[i]; heap_pos[i] = tp;
      i = m;
    end
  endfunction

  // Priority flood over the stored grid; the total saturates at the field width.
  function automatic logic [WATER_W-1:0] trapped_water(int rows, int cols);
    longint water;
    int unsigned lvl, h;
    int pos, r0, c0, r1, c1, n;
    water = 0;
    heap_n = 0;
    for (int k = 0; k < rows * cols; k++) begin
      seen[k] = 0;
    end
    for (int k = 0; k < rows * cols; k++) begin
      if (k / cols == 0 || k / cols == rows - 1 || k % cols == 0 || k % cols == cols - 1) begin
        seen[k] = 1;
        heap_insert(heights[k], k);
      end
    end
    while (heap_n > 0) begin
      heap_take(lvl, pos);
      r0 = pos / cols;
      c0 = pos % cols;
      for (int d = 0; d < 4; d++) begin
        r1 = r0 + ROW_STEP[d];
        c1 = c0 + COL_STEP[d];
        if (r1 < 0 || c1 < 0 || r1 >= rows || c1 >= cols) continue;
        n = r1 * cols + c1;
        if (seen[n]) continue;
        h = heights[n];
        if (lvl > h) begin
          water = water + (lvl - h);
          if (water > longint'(WATER_MAX)) water = longint'(WATER_MAX);
        end
        seen[n] = 1;
        heap_insert(lvl > h ? lvl : h, n);
      end
    end
    return water[WATER_W-1:0];
  endfunction

  // Advances the predictor by one accepted word; returns 1 when a grid closes.
  function automatic bit grid_step(cell_in_t w, output result_t res);
    bit ok;
    res = '0;
    if (cells_in < CELL_CAP) heights[cells_in] = w.cell_height;
    if (cells_in <= CELL_CAP) cells_in++;
    if (!w.last_cell) return 0;
    ok = grid_rows_q >= 1 && grid_rows_q <= MAX_ROWS_DEF &&
         grid_cols_q >= 1 && grid_cols_q <= MAX_COLS_DEF &&
         cells_in == int'(grid_rows_q) * int'(grid_cols_q);
    if (ok) res.water_total = trapped_water(grid_rows_q, grid_cols_q);
    else res.status = 1'b1;
    cells_in = 0;
    return 1;
  endfunction

  // Result side: check each popped word, then decide on the next pop.
  initial begin
    int hold_left;
    result_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        results_seen++;
        if (pending_totals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result word %h", result);
        end else begin
          want = pending_totals.pop_front();
          if (result.water_total !== want.water_total || result.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: water %0d status %0d, expected water %0d status %0d",
                       result.water_total, result.status, want.water_total, want.status);
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no handshake at all.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_MAX) begin
      $display("ERROR: no progress for %0d cycles", WATCH_MAX);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GRID_ROWS) grid_rows_q = val;
    else if (idx == REG_GRID_COLS) grid_cols_q = val;
    @(posedge clk);
  endtask

  // Offers one word, sometimes after a random gap; predicts once it is taken.
  task automatic send_word(cell_in_t w, bit typed, result_t want);
    result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full);
    words_sent++;
    if (grid_step(w, res)) begin
      pending_totals.push_back(typed ? want : res);
      grids_done++;
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [HEIGHT_W-1:0] pick_height(int style);
    case (style)
      0: return HEIGHT_W'($urandom);
      1: return HEIGHT_W'($urandom_range(15));
      default: return $urandom_range(1) ? '1 : HEIGHT_W'($urandom_range(40));
    endcase
  endfunction

  // Sends one grid of count words with random heights.
  task automatic send_grid(int count);
    cell_in_t w;
    int style;
    result_t none;
    none = '0;
    style = $urandom_range(2);
    for (int k = 0; k < count; k++) begin
      w.cell_height = pick_height(style);
      w.last_cell = (k == count - 1);
      send_word(w, 0, none);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return CFG_W'(0);
    if (sel < 8) return CFG_W'($urandom_range(65, 127));
    if (sel < 14) return CFG_W'(1);
    return CFG_W'($urandom_range(2, 9));
  endfunction

  task automatic random_phase(int words);
    int stop, count, prod;
    stop = words_sent + words;
    while (words_sent < stop) begin
      if ($urandom_range(3) == 0) begin
        wait_idle();
        write_reg(REG_GRID_ROWS, pick_dim());
        write_reg(REG_GRID_COLS, pick_dim());
        // A tall strip now and then, kept small in area.
        if ($urandom_range(9) == 0) begin
          write_reg(REG_GRID_ROWS, CFG_W'(64));
          write_reg(REG_GRID_COLS, CFG_W'($urandom_range(1, 3)));
        end
      end
      prod = int'(grid_rows_q) * int'(grid_cols_q);
      if (prod == 0 || grid_rows_q > 64 || grid_cols_q > 64) count = $urandom_range(1, 10);
      else if ($urandom_range(99) < 85) count = prod;
      else count = (prod > 1 && $urandom_range(1)) ? prod - $urandom_range(1, prod - 1)
                                                   : prod + $urandom_range(1, 3);
      send_grid(count);
    end
  endtask

  initial begin
    grid_row_t dir_tab [7];
    cell_in_t w;
    int r, c;
    dir_tab = '{
      '{1, 1, 1, 1, FILL_ZERO, '{28'd0, 1'b0}},
      '{1, 1, 0, 1, FILL_MAX, '{28'd0, 1'b0}},
      '{3, 3, 0, 9, FILL_BOWL, '{28'd65535, 1'b0}},
      '{2, 2, 0, 3, FILL_MAX, '{28'd0, 1'b1}},
      '{2, 2, 0, 5, FILL_ZERO, '{28'd0, 1'b1}},
      '{0, 3, 0, 3, FILL_ZERO, '{28'd0, 1'b1}},
      '{127, 1, 0, 1, FILL_ZERO, '{28'd0, 1'b1}}
    };
    cells_in = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed grids: trivial sizes, full heights, a bowl and the error cases.
    foreach (dir_tab[i]) begin
      wait_idle();
      write_reg(REG_GRID_ROWS, CFG_W'(dir_tab[i].rows));
      write_reg(REG_GRID_COLS, CFG_W'(dir_tab[i].cols));
      // Writes to the unused indexes must leave the grid size alone.
      if (dir_tab[i].junk_write) begin
        write_reg(2'd2, 7'd5);
        write_reg(2'd3, 7'd127);
      end
      for (int k = 0; k < dir_tab[i].count; k++) begin
        r = k / dir_tab[i].cols;
        c = k % dir_tab[i].cols;
        case (dir_tab[i].fill)
          FILL_ZERO: w.cell_height = '0;
          FILL_MAX: w.cell_height = '1;
          default: w.cell_height = (r == 0 || c == 0 || r == dir_tab[i].rows - 1 ||
                                    c == dir_tab[i].cols - 1) ? '1 : '0;
        endcase
        w.last_cell = (k == dir_tab[i].count - 1);
        send_word(w, 1, dir_tab[i].want);
      end
    end

    // Random grids in three idling patterns.
    random_phase(220);
    hold_req = 1;
    random_phase(40);
    wait_idle();
    send_idle_pct = 50;
    recv_idle_pct = 28;
    random_phase(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(220);

    // One larger square grid.
    wait_idle();
    write_reg(REG_GRID_ROWS, CFG_W'(32));
    write_reg(REG_GRID_COLS, CFG_W'(32));
    send_grid(1024);
    wait_idle();

    $display("Checked %0d grids (%0d words, %0d results), from 1x1 up to 64-row strips",
             grids_done, words_sent, results_seen);
    $display("and a 32x32 grid, with count and size errors and output back-pressure.");
    if (mismatches == 0 && pending_totals.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
